// File: rtl/core/baseline_mean_subtract_macros.svh
// ----------------------------------------------------------------------------
// Baseline mean subtract assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef BASELINE_MEAN_SUBTRACT_MACROS_SVH
`define BASELINE_MEAN_SUBTRACT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define BMS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// Check that a condition never holds outside reset
`define BMS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);
`else
`define BMS_ASSERT(label, clk, rstn, prop, msg)
`define BMS_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

// File: rtl/core/bms_pkg.sv
// ----------------------------------------------------------------------------
// Baseline mean subtract package
// Sizes, types, sequencer states and the structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

    localparam int CHANNELS = 16;
    localparam int ROW_MAX  = 32;

    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 4;
    localparam int FILT_W   = 17;
    localparam int MASK_W   = 16;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 32;
    localparam int MEAN_W   = 16;

    localparam int FILL_W    = $clog2(ROW_MAX + 1);
    localparam int ADDR_W    = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int CIDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROWSUM_W  = SAMPLE_W + FILL_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [CH_W:0]     CH_LIMIT = (CH_W + 1)'(CHANNELS);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ROW_MAX);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [CH_W-1:0]     chan_t;
    typedef logic signed [FILT_W-1:0]   filt_t;
    typedef logic        [MASK_W-1:0]   mask_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [CNT_W-1:0]    cnt_t;
    typedef logic signed [MEAN_W-1:0]   mean_t;
    typedef logic        [FILL_W-1:0]   fill_t;
    typedef logic signed [ROWSUM_W-1:0] rowsum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_READ,
        ST_LOAD,
        ST_WAIT
    } bms_state_t;

    // Commands from the sequencer to the channel statistics
    typedef struct packed {
        logic    clear;
        logic    accum;
        logic    mean_wr;
        chan_t   ch;
        fill_t   row_len;
        rowsum_t row_sum;
        mean_t   mean;
    } bms_stats_ctrl_t;

    // Statistics of the selected channel
    typedef struct packed {
        logic  room;
        sum_t  sum;
        cnt_t  count;
        mean_t mean;
    } bms_stats_view_t;

endpackage

`default_nettype wire

// File: rtl/core/bms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bms_div.sv
// ----------------------------------------------------------------------------
// Baseline mean divider
// Bit-serial restoring divider: signed sum over unsigned count, one quotient
// bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_div (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire bms_pkg::sum_t   dividend,
    input  wire bms_pkg::cnt_t   divisor,
    output logic                 done,
    output bms_pkg::mean_t       quotient
);

    import bms_pkg::*;

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [CNT_W:0]   rem_shift;
    logic [CNT_W:0]   diff;
    logic [SUM_W-1:0] dividend_mag;
    logic [MEAN_W:0]  mag;
    logic [MEAN_W:0]  q_signed;

    // Magnitude of the dividend; the sign is restored at the end
    assign dividend_mag = dividend[SUM_W-1] ? SUM_W'(~dividend + 1'b1) : dividend;

    // Shift one dividend bit into the remainder and trial subtract
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend_mag;
            rem_next = '0;
            dvs_next = divisor;
            neg_next = dividend[SUM_W-1];
            cnt_next = DIV_CNT_W'(SUM_W - 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!diff[CNT_W]) begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // The mean fits in MEAN_W signed bits; apply the sign
    assign mag      = quo_reg[MEAN_W:0];
    assign q_signed = neg_reg ? (~mag + 1'b1) : mag;
    assign quotient = q_signed[MEAN_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/bms_stats.sv
// ----------------------------------------------------------------------------
// Baseline channel statistics
// Per-channel sum, count and mean, with the global clear and the
// count headroom check for the selected channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_stats (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire bms_pkg::bms_stats_ctrl_t ctrl,
    output bms_pkg::bms_stats_view_t      view
);

    import bms_pkg::*;

    sum_t  sum_reg   [CHANNELS];
    cnt_t  count_reg [CHANNELS];
    mean_t mean_reg  [CHANNELS];

    logic [CIDX_W-1:0] idx;
    logic [CNT_W:0]    count_ext;
    sum_t              sum_add;

    assign idx       = ctrl.ch[CIDX_W-1:0];
    assign count_ext = {1'b0, count_reg[idx]} + (CNT_W + 1)'(ctrl.row_len);
    assign sum_add   = sum_reg[idx] + SUM_W'(ctrl.row_sum);

    // Clear on baseline start, accumulate a row, store the new mean
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
                mean_reg[i]  <= '0;
            end
        end else begin
            if (ctrl.accum) begin
                sum_reg[idx]   <= sum_add;
                count_reg[idx] <= count_ext[CNT_W-1:0];
            end
            if (ctrl.mean_wr) begin
                mean_reg[idx] <= ctrl.mean;
            end
        end
    end

    // Selected channel view; room drops when the count would overflow its width
    always_comb begin
        view.room  = ~count_ext[CNT_W];
        view.sum   = sum_reg[idx];
        view.count = count_reg[idx];
        view.mean  = mean_reg[idx];
    end

endmodule

`default_nettype wire

// File: rtl/core/baseline_mean_subtract.sv
// ----------------------------------------------------------------------------
// Baseline mean subtract
// Per-channel running-mean baseline removal for buffered sample rows.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle and buffered until the request that
// carries row_last; the block then stops taking requests until the row has
// been replayed. The row update follows; when the row is accumulated during
// the baseline period, the bit-serial divider then works out the mean over
// the 48-bit sum. Each buffered sample is then read and replayed through a
// load state, set by the registered read of the row buffer, and a wait state
// that holds until the result is taken.
`default_nettype none

`include "baseline_mean_subtract_macros.svh"

module baseline_mean_subtract (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire bms_pkg::mask_t   cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bms_pkg::sample_t s_sample,
    input  wire bms_pkg::chan_t   s_channel,
    input  wire logic             s_baseline_on,
    input  wire logic             s_block_start,
    input  wire logic             s_row_last,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bms_pkg::filt_t        m_filtered,
    output bms_pkg::chan_t        m_out_channel,
    output logic                  m_out_last
);

    import bms_pkg::*;

    bms_state_t state_reg, state_next;

    fill_t   fill_reg, fill_next;
    fill_t   row_len_reg, row_len_next;
    rowsum_t row_sum_reg, row_sum_next;
    chan_t   ch_reg, ch_next;
    logic    flag_reg, flag_next;
    logic    prev_flag_reg, prev_flag_next;
    mask_t   mask_reg, mask_next;
    fill_t   emit_idx_reg, emit_idx_next;
    filt_t   m_filtered_reg, m_filtered_next;
    logic    m_last_reg, m_last_next;

    logic    accept;
    logic    store_ok;
    fill_t   fill_inc;
    rowsum_t sample_ext;
    logic    valid_ch;
    logic    accum_ok;
    mean_t   mean_sel;

    logic    rd_en;
    sample_t rd_data;
    logic    div_start;
    logic    div_done;
    mean_t   div_quot;
    logic    stats_accum;
    logic    stats_mean_wr;
    logic    out_load;

    bms_stats_ctrl_t stats_ctrl;
    bms_stats_view_t stats_view;

    assign accept     = s_valid && s_ready;
    assign store_ok   = fill_reg < FILL_MAX;
    assign fill_inc   = fill_reg + 1'b1;
    assign sample_ext = ROWSUM_W'(s_sample);
    assign valid_ch   = {1'b0, ch_reg} < CH_LIMIT;
    assign accum_ok   = valid_ch && flag_reg && stats_view.room;
    assign mean_sel   = (valid_ch && mask_reg[ch_reg]) ? stats_view.mean : '0;

    // Row buffer
    bms_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ROW_MAX)
    ) u_row_ram (
        .clk     (aclk),
        .wr_en   (accept && store_ok),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_sample),
        .rd_en   (rd_en),
        .rd_addr (emit_idx_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Channel statistics
    always_comb begin
        stats_ctrl.clear   = accept && s_block_start && s_baseline_on && !prev_flag_reg;
        stats_ctrl.accum   = stats_accum;
        stats_ctrl.mean_wr = stats_mean_wr;
        stats_ctrl.ch      = ch_reg;
        stats_ctrl.row_len = row_len_reg;
        stats_ctrl.row_sum = row_sum_reg;
        stats_ctrl.mean    = div_quot;
    end

    bms_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (stats_ctrl),
        .view    (stats_view)
    );

    // Mean divider
    bms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (stats_view.sum),
        .divisor  (stats_view.count),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_row_last) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                state_next = accum_ok ? ST_DIV_GO : ST_READ;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (m_ready) begin
                    state_next = m_last_reg ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        rd_en         = 1'b0;
        div_start     = 1'b0;
        stats_accum   = 1'b0;
        stats_mean_wr = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_ACCUM: begin
                stats_accum = accum_ok;
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                stats_mean_wr = div_done;
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_LOAD: begin
                out_load = 1'b1;
            end
            ST_WAIT: begin
                m_valid = 1'b1;
                rd_en   = m_ready && !m_last_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Buffer the row, track the baseline flag edge, latch the row close
    always_comb begin
        fill_next      = fill_reg;
        row_sum_next   = row_sum_reg;
        row_len_next   = row_len_reg;
        ch_next        = ch_reg;
        flag_next      = flag_reg;
        prev_flag_next = prev_flag_reg;
        if (accept) begin
            if (s_block_start) begin
                prev_flag_next = s_baseline_on;
            end
            if (store_ok) begin
                fill_next    = fill_inc;
                row_sum_next = (fill_reg == '0) ? sample_ext : row_sum_reg + sample_ext;
            end
            if (s_row_last) begin
                row_len_next = store_ok ? fill_inc : fill_reg;
                fill_next    = '0;
                ch_next      = s_channel;
                flag_next    = s_baseline_on;
            end
        end
    end

    // Replay index and output register
    always_comb begin
        emit_idx_next   = emit_idx_reg;
        m_filtered_next = m_filtered_reg;
        m_last_next     = m_last_reg;
        if (state_reg == ST_ACCUM) begin
            emit_idx_next = '0;
        end
        if (state_reg == ST_WAIT && m_ready && !m_last_reg) begin
            emit_idx_next = emit_idx_reg + 1'b1;
        end
        if (out_load) begin
            m_filtered_next = FILT_W'(rd_data) - FILT_W'(mean_sel);
            m_last_next     = fill_t'(emit_idx_reg + 1'b1) == row_len_reg;
        end
    end

    assign mask_next = cfg_wr_en ? cfg_wr_data : mask_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            prev_flag_reg <= 1'b0;
            mask_reg      <= '0;
            emit_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            prev_flag_reg <= prev_flag_next;
            mask_reg      <= mask_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        row_sum_reg    <= row_sum_next;
        row_len_reg    <= row_len_next;
        ch_reg         <= ch_next;
        flag_reg       <= flag_next;
        m_filtered_reg <= m_filtered_next;
        m_last_reg     <= m_last_next;
    end

    assign m_filtered    = m_filtered_reg;
    assign m_out_channel = ch_reg;
    assign m_out_last    = m_last_reg;

    // Checks
    `BMS_ASSERT_NEVER(a_no_take_while_emit, aclk, aresetn, s_ready && m_valid, "input taken during replay")
    `BMS_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_MAX, "row fill beyond row size")
    `BMS_ASSERT(a_last_frees_input, aclk, aresetn, m_valid && m_ready && m_out_last |=> s_ready, "input not freed after row end")
    `BMS_ASSERT(a_div_done_waited, aclk, aresetn, div_done |-> state_reg == ST_DIV_WAIT, "divider done outside wait")

endmodule

`default_nettype wire

// File: tb/bms_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baseline mean subtract checker
// Watches the register port and both channels of the block, keeps its own
// per-channel sum, count and mean, predicts every replayed sample and
// compares each result request with the oldest prediction.
// ----------------------------------------------------------------------------
module bms_filter_checker
    import bms_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cfg_wr_en,
    input  wire mask_t   cfg_wr_data,
    input  wire logic    s_valid,
    input  wire logic    s_ready,
    input  wire sample_t s_sample,
    input  wire chan_t   s_channel,
    input  wire logic    s_baseline_on,
    input  wire logic    s_block_start,
    input  wire logic    s_row_last,
    input  wire logic    m_valid,
    input  wire logic    m_ready,
    input  wire filt_t   m_filtered,
    input  wire chan_t   m_out_channel,
    input  wire logic    m_out_last,
    output int unsigned  error_count,
    output int unsigned  outstanding
);

    typedef struct packed {
        filt_t filtered;
        chan_t channel;
        logic  last;
    } filtered_sample_t;

    filtered_sample_t filtered_due[$];

    mask_t       mask_now;
    sum_t        ch_sum   [CHANNELS];
    cnt_t        ch_count [CHANNELS];
    mean_t       ch_mean  [CHANNELS];
    sample_t     row_buf  [ROW_MAX];
    int unsigned row_len;
    logic        flag_seen;

    // Zero every channel's statistics
    task automatic clear_stats();
        for (int c = 0; c < CHANNELS; c++) begin
            ch_sum[c]   = '0;
            ch_count[c] = '0;
            ch_mean[c]  = '0;
        end
    endtask

    // Close the buffered row: update the channel mean, then queue the replay
    task automatic close_row(input chan_t ch, input logic flag);
        longint           row_total;
        mean_t            applied;
        int               diff;
        filtered_sample_t item;
        row_total = 0;
        applied   = '0;
        // Accumulate only in the baseline period and while the count has room
        if (ch < CHANNELS && flag &&
            (longint'({32'b0, ch_count[ch]}) + row_len <= 64'hFFFF_FFFF)) begin
            for (int k = 0; k < row_len; k++)
                row_total += row_buf[k];
            ch_sum[ch]   = ch_sum[ch] + sum_t'(row_total);
            ch_count[ch] = ch_count[ch] + cnt_t'(row_len);
            ch_mean[ch]  = mean_t'(longint'(ch_sum[ch]) / longint'({32'b0, ch_count[ch]}));
        end
        if (ch < CHANNELS && mask_now[ch])
            applied = ch_mean[ch];
        for (int k = 0; k < row_len; k++) begin
            diff          = int'(row_buf[k]) - int'(applied);
            item.filtered = filt_t'(diff);
            item.channel  = ch;
            item.last     = (k == row_len - 1);
            filtered_due.push_back(item);
        end
        row_len = 0;
    endtask

    // Absorb one accepted sample request
    task automatic take_sample(input sample_t smp, input chan_t ch, input logic flag,
                               input logic start, input logic last);
        // Clear statistics on a rising baseline flag at block start
        if (start) begin
            if (flag && !flag_seen)
                clear_stats();
            flag_seen = flag;
        end
        // Drop samples past the end of the row buffer
        if (row_len < ROW_MAX) begin
            row_buf[row_len] = smp;
            row_len++;
        end
        if (last)
            close_row(ch, flag);
    endtask

    always @(posedge aclk) begin : watch
        filtered_sample_t got;
        filtered_sample_t want;
        if (!aresetn) begin
            clear_stats();
            mask_now  = '0;
            row_len   = 0;
            flag_seen = 1'b0;
            filtered_due.delete();
        end else begin
            if (cfg_wr_en)
                mask_now = cfg_wr_data;
            if (s_valid && s_ready)
                take_sample(s_sample, s_channel, s_baseline_on, s_block_start, s_row_last);
            // Compare each result request with the oldest prediction
            if (m_valid && m_ready) begin
                got.filtered = m_filtered;
                got.channel  = m_out_channel;
                got.last     = m_out_last;
                if (filtered_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: filtered %0d channel %0d last %0b",
                             $time, m_filtered, m_out_channel, m_out_last);
                end else begin
                    want = filtered_due.pop_front();
                    // Report as filtered/channel/last
                    if (got != want) begin
                        error_count++;
                        $display("%0t: mismatch: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                                 $time, want.filtered, want.channel, want.last,
                                 m_filtered, m_out_channel, m_out_last);
                    end
                end
            end
        end
        outstanding = filtered_due.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baseline mean subtract testbench
// Sends directed and randomized blocks of sample rows with random idling on
// both channels, sweeps the subtract mask between idle phases, and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
    import bms_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int STALL_LIMIT     = 5000;
    localparam int PHASE_ITEMS     = 80;
    localparam int TAIL_ITEMS      = 60;

    logic    aclk          = 1'b0;
    logic    aresetn       = 1'b0;
    logic    cfg_wr_en     = 1'b0;
    mask_t   cfg_wr_data   = '0;
    logic    s_valid       = 1'b0;
    logic    s_ready;
    sample_t s_sample      = '0;
    chan_t   s_channel     = '0;
    logic    s_baseline_on = 1'b0;
    logic    s_block_start = 1'b0;
    logic    s_row_last    = 1'b0;
    logic    m_valid;
    logic    m_ready       = 1'b0;
    filt_t   m_filtered;
    chan_t   m_out_channel;
    logic    m_out_last;

    int unsigned error_count;
    int unsigned outstanding;
    int unsigned idle_cycles = 0;
    int unsigned items_sent  = 0;
    logic        hold_off_req = 1'b0;
    logic        steady_tail  = 1'b0;
    logic        sender_calm  = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    baseline_mean_subtract DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_channel     (s_channel),
        .s_baseline_on (s_baseline_on),
        .s_block_start (s_block_start),
        .s_row_last    (s_row_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered    (m_filtered),
        .m_out_channel (m_out_channel),
        .m_out_last    (m_out_last)
    );

    bms_filter_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_channel     (s_channel),
        .s_baseline_on (s_baseline_on),
        .s_block_start (s_block_start),
        .s_row_last    (s_row_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered    (m_filtered),
        .m_out_channel (m_out_channel),
        .m_out_last    (m_out_last),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    // Count cycles without any request or register write
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End the run when the block stops moving
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("baseline_mean_subtract test failed");
        $finish;
    end

    // Throttle the result channel: random stall bursts, one long hold-off on demand
    initial begin : receiver
        logic held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_req && !held) begin
                held    = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(0, 24)) @(posedge aclk);
            end
        end
    end

    // Offer one sample request and hold it until accepted, then maybe idle
    task automatic offer(input sample_t smp, input chan_t ch, input logic flag,
                         input logic start, input logic last);
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_channel     <= ch;
        s_baseline_on <= flag;
        s_block_start <= start;
        s_row_last    <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
        if (!steady_tail && !sender_calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic await_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mask(input mask_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short rows, now and then a full or overflowing one
    function automatic int pick_row_len();
        int pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            return $urandom_range(ROW_MAX + 1, ROW_MAX + 4);
        else if (pick == 1)
            return ROW_MAX;
        else if (pick < 6)
            return $urandom_range(8, 20);
        return $urandom_range(1, 6);
    endfunction

    // Send one row around a baseline level, with occasional stray fields
    task automatic send_row(input chan_t ch, input int len, input logic flag,
                            input logic opens_block, input sample_t base);
        sample_t smp;
        chan_t   item_ch;
        logic    item_flag;
        logic    item_start;
        logic    is_last;
        for (int k = 0; k < len; k++) begin
            is_last = (k == len - 1);
            if ($urandom_range(0, 3) == 0)
                smp = sample_t'($urandom);
            else
                smp = sample_t'(int'(base) + int'($urandom_range(0, 400)) - 200);
            item_ch    = (is_last || $urandom_range(0, 7) != 0) ? ch : chan_t'($urandom);
            item_flag  = ($urandom_range(0, 15) == 0) ? !flag : flag;
            item_start = (opens_block && k == 0) || ($urandom_range(0, 31) == 0);
            offer(smp, item_ch, item_flag, item_start, is_last);
        end
    endtask

    // Send a block: a few rows sharing one baseline flag
    task automatic send_block();
        logic    flag;
        logic    opens;
        int      rows;
        sample_t base;
        flag        = ($urandom_range(0, 2) != 0);
        opens       = ($urandom_range(0, 7) != 0);
        sender_calm = ($urandom_range(0, 3) == 0);
        rows        = $urandom_range(1, 4);
        base        = sample_t'($urandom);
        for (int r = 0; r < rows; r++)
            send_row(chan_t'($urandom_range(0, CHANNELS - 1)), pick_row_len(), flag,
                     opens && r == 0, base);
    endtask

    // Send blocks until the item count is reached; optionally hold off the
    // receiver while the phase keeps offering
    task automatic run_blocks(input int unsigned count, input logic with_hold);
        int unsigned stop_at;
        stop_at = items_sent + count;
        if (with_hold)
            hold_off_req <= 1'b1;
        while (items_sent < stop_at)
            send_block();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Rising baseline flag clears; full-scale rows, mask still at reset
        offer(sample_t'(32767), 4'd0, 1'b1, 1'b1, 1'b0);
        offer(sample_t'(32767), 4'd0, 1'b1, 1'b0, 1'b0);
        offer(sample_t'(32767), 4'd0, 1'b1, 1'b0, 1'b1);
        offer(sample_t'(-32768), 4'd15, 1'b1, 1'b0, 1'b0);
        offer(sample_t'(-32768), 4'd15, 1'b1, 1'b0, 1'b1);
        // Mixed channels: the row goes to the channel of its last sample
        offer(sample_t'(5), 4'd3, 1'b1, 1'b0, 1'b0);
        offer(sample_t'(7), 4'd9, 1'b1, 1'b0, 1'b0);
        offer(sample_t'(9), 4'd5, 1'b1, 1'b0, 1'b1);
        // Negative mean truncates toward zero
        offer(sample_t'(-7), 4'd6, 1'b1, 1'b0, 1'b0);
        offer(sample_t'(-2), 4'd6, 1'b1, 1'b0, 1'b1);
        // Flag low: no accumulation
        offer(sample_t'(1234), 4'd1, 1'b0, 1'b1, 1'b1);

        await_idle();
        write_mask(16'hFFFF);

        // Subtract every mean, including the extreme differences
        offer(sample_t'(-32768), 4'd0, 1'b0, 1'b1, 1'b1);
        offer(sample_t'(32767), 4'd15, 1'b0, 1'b0, 1'b1);
        offer(sample_t'(100), 4'd5, 1'b0, 1'b0, 1'b1);
        offer(sample_t'(0), 4'd6, 1'b0, 1'b0, 1'b1);
        // Rising edge clears again, then a held flag keeps accumulating
        offer(sample_t'(10), 4'd15, 1'b1, 1'b1, 1'b0);
        offer(sample_t'(20), 4'd15, 1'b1, 1'b0, 1'b1);
        offer(sample_t'(30), 4'd15, 1'b1, 1'b1, 1'b1);
        // Overflowing row: samples past the buffer are dropped
        send_row(4'd2, ROW_MAX + 3, 1'b0, 1'b1, sample_t'(0));

        // Random phases across mask settings
        run_blocks(PHASE_ITEMS, 1'b1);
        await_idle();
        write_mask(mask_t'($urandom));
        run_blocks(PHASE_ITEMS / 2, 1'b0);
        await_idle();
        run_blocks(PHASE_ITEMS / 2, 1'b0);
        await_idle();
        write_mask(16'h0000);
        run_blocks(PHASE_ITEMS, 1'b0);
        await_idle();
        write_mask(16'h5555);
        run_blocks(PHASE_ITEMS, 1'b0);
        await_idle();
        write_mask(mask_t'($urandom));
        steady_tail = 1'b1;
        run_blocks(TAIL_ITEMS, 1'b0);
        await_idle();

        if (error_count == 0)
            $display("baseline_mean_subtract test passed");
        else
            $display("baseline_mean_subtract test failed");
        $finish;
    end

endmodule
